// ----- hw/rtl/tlcd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcd_pkg
// shared widths, register map, character codes and defaults of the csv
// tile layer decoder
// ----------------------------------------------------------------------------
package tlcd_pkg;

    // payload widths
    localparam int CHAR_W   = 8;
    localparam int TILE_W_W = 11;
    localparam int MAP_W_W  = 13;
    localparam int POS_X_W  = 22;
    localparam int POS_Y_W  = 26;
    localparam int NUM_W    = 16;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    localparam logic [1:0] REG_TILE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MAP_WIDTH   = 2'd2;
    localparam logic [1:0] REG_TS_COLUMNS  = 2'd3;

    localparam logic [TILE_W_W-1:0] TILE_WIDTH_RST  = 11'd32;
    localparam logic [TILE_W_W-1:0] TILE_HEIGHT_RST = 11'd32;
    localparam logic [MAP_W_W-1:0]  MAP_WIDTH_RST   = 13'd64;
    localparam logic [MAP_W_W-1:0]  TS_COLUMNS_RST  = 13'd16;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_0   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9   = 8'h39;
    localparam int                DEC_BASE = 10;

    // parameter defaults
    localparam int unsigned     MAP_TILES_DEF   = 65536;
    localparam longint unsigned MAX_TILE_ID_DEF = 64'd65535;

endpackage

// ----- hw/rtl/tile_layer_csv_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_layer_csv_decoder
// decodes comma-separated tile ids of one map layer, one character per
// transaction, and emits map position and tileset source rectangle per tile
// ----------------------------------------------------------------------------
// a digit, a NUL or a separator that yields no tile leaves in_stall low
// a tile with a nonzero id keeps in_stall high through two divider passes
// at 1 quotient bit per cycle, four multiplier passes and one transfer,
// longer while the previous tile still waits in the stalled output register
// DIV_W = max(clog2(MAP_TILES), bits of MAX_TILE_ID)
// reset: asynchronous active-low, clears decode state, reloads register defaults
module tile_layer_csv_decoder #(
    parameter int unsigned     MAP_TILES   = tlcd_pkg::MAP_TILES_DEF,
    parameter longint unsigned MAX_TILE_ID = tlcd_pkg::MAX_TILE_ID_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // register port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tlcd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tlcd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tlcd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    // character input
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tlcd_pkg::CHAR_W-1:0]      text_char,
    // tile output
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tlcd_pkg::POS_X_W-1:0]     pos_x,
    output logic [tlcd_pkg::POS_Y_W-1:0]     pos_y,
    output logic [tlcd_pkg::POS_X_W-1:0]     src_x,
    output logic [tlcd_pkg::POS_Y_W-1:0]     src_y,
    output logic [tlcd_pkg::NUM_W-1:0]       tile_number,
    output logic                             overflowed
);
    import tlcd_pkg::*;

    // derived widths
    localparam int CNT_W  = $clog2(MAP_TILES);
    localparam int ID_W   = $clog2(MAX_TILE_ID + 64'd1);
    localparam int DIV_W  = (CNT_W > ID_W) ? CNT_W : ID_W;
    localparam int DCNT_W = $clog2(DIV_W);
    localparam int ACC_W  = ID_W + 4;
    localparam int PROD_W = POS_Y_W + TILE_W_W;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // multiplier passes
    localparam logic [1:0] MUL_POS_X = 2'd0;
    localparam logic [1:0] MUL_POS_Y = 2'd1;
    localparam logic [1:0] MUL_SRC_X = 2'd2;
    localparam logic [1:0] MUL_SRC_Y = 2'd3;

    // configuration registers
    logic [TILE_W_W-1:0] tile_w_reg, tile_w_next;
    logic [TILE_W_W-1:0] tile_h_reg, tile_h_next;
    logic [MAP_W_W-1:0]  map_w_reg,  map_w_next;
    logic [MAP_W_W-1:0]  cols_reg,   cols_next;

    // decode state
    logic [ID_W-1:0]  accum_reg,  accum_next;
    logic             digits_reg, digits_next;
    logic             novf_reg,   novf_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;

    // sequencer and shared units
    logic [1:0]        state_reg, state_next;
    logic [DCNT_W-1:0] dcnt_reg,  dcnt_next;
    logic              pass_reg,  pass_next;
    logic [1:0]        mstep_reg, mstep_next;
    logic [DIV_W-1:0]  dvd_reg,   dvd_next;
    logic [MAP_W_W-1:0] rem_reg,  rem_next;
    logic [MAP_W_W-1:0] dvs_reg,  dvs_next;
    logic [CNT_W-1:0]  q0_reg,    q0_next;
    logic [MAP_W_W-1:0] r0_reg,   r0_next;
    logic [ID_W-1:0]   id_reg,    id_next;
    logic              ovf_reg,   ovf_next;

    // result staging and output register
    logic [POS_X_W-1:0] res_px_reg, res_px_next;
    logic [POS_Y_W-1:0] res_py_reg, res_py_next;
    logic [POS_X_W-1:0] res_sx_reg, res_sx_next;
    logic [POS_Y_W-1:0] res_sy_reg, res_sy_next;
    logic               out_valid_reg, out_valid_next;
    logic [POS_X_W-1:0] out_px_reg, out_px_next;
    logic [POS_Y_W-1:0] out_py_reg, out_py_next;
    logic [POS_X_W-1:0] out_sx_reg, out_sx_next;
    logic [POS_Y_W-1:0] out_sy_reg, out_sy_next;
    logic [NUM_W-1:0]   out_num_reg, out_num_next;
    logic               out_ovf_reg, out_ovf_next;

    // combinational helpers
    logic               cfg_wr;
    logic               in_acc;
    logic               is_digit;
    logic [ACC_W-1:0]   acc_sum;
    logic [MAP_W_W:0]   rem_sh;
    logic [MAP_W_W:0]   rem_diff;
    logic               rem_ge;
    logic [MAP_W_W-1:0] rem_step;
    logic [DIV_W-1:0]   dvd_step;
    logic [POS_Y_W-1:0] mul_a;
    logic [TILE_W_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod;
    logic               out_free;
    logic [MAP_W_W-1:0] map_w_eff;
    logic [MAP_W_W-1:0] cols_eff;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite & pready;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_acc   = in_valid & ~in_stall;
    assign out_free = ~out_valid_reg | ~out_stall;

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_TILE_WIDTH:  prdata = APB_DATA_W'(tile_w_reg);
            REG_TILE_HEIGHT: prdata = APB_DATA_W'(tile_h_reg);
            REG_MAP_WIDTH:   prdata = APB_DATA_W'(map_w_reg);
            REG_TS_COLUMNS:  prdata = APB_DATA_W'(cols_reg);
            default:         prdata = '0;
        endcase
    end

    // a zero divisor acts as one
    assign map_w_eff = (map_w_reg == '0) ? MAP_W_W'(1) : map_w_reg;
    assign cols_eff  = (cols_reg == '0)  ? MAP_W_W'(1) : cols_reg;

    // digit accumulation: times ten plus digit, saturating
    assign is_digit = (text_char >= CHAR_0) && (text_char <= CHAR_9);
    assign acc_sum  = ACC_W'(accum_reg) * ACC_W'(DEC_BASE)
                    + ACC_W'(text_char - CHAR_0);

    // shared divider: one restoring step, one quotient bit per cycle
    assign rem_sh   = {rem_reg, dvd_reg[DIV_W-1]};
    assign rem_diff = rem_sh - {1'b0, dvs_reg};
    assign rem_ge   = (rem_sh >= {1'b0, dvs_reg});
    assign rem_step = rem_ge ? rem_diff[MAP_W_W-1:0] : rem_sh[MAP_W_W-1:0];
    assign dvd_step = {dvd_reg[DIV_W-2:0], rem_ge};

    // shared multiplier: operand select per pass, low bits kept
    always_comb
    begin
        case (mstep_reg)
            MUL_POS_X:
            begin
                mul_a = POS_Y_W'(r0_reg);
                mul_b = tile_w_reg;
            end
            MUL_POS_Y:
            begin
                mul_a = POS_Y_W'(q0_reg);
                mul_b = tile_h_reg;
            end
            MUL_SRC_X:
            begin
                mul_a = POS_Y_W'(rem_reg);
                mul_b = tile_w_reg;
            end
            MUL_SRC_Y:
            begin
                mul_a = POS_Y_W'(dvd_reg);
                mul_b = tile_h_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // next state
    always_comb
    begin
        tile_w_next    = tile_w_reg;
        tile_h_next    = tile_h_reg;
        map_w_next     = map_w_reg;
        cols_next      = cols_reg;
        accum_next     = accum_reg;
        digits_next    = digits_reg;
        novf_next      = novf_reg;
        cnt_next       = cnt_reg;
        state_next     = state_reg;
        dcnt_next      = dcnt_reg;
        pass_next      = pass_reg;
        mstep_next     = mstep_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        q0_next        = q0_reg;
        r0_next        = r0_reg;
        id_next        = id_reg;
        ovf_next       = ovf_reg;
        res_px_next    = res_px_reg;
        res_py_next    = res_py_reg;
        res_sx_next    = res_sx_reg;
        res_sy_next    = res_sy_reg;
        out_valid_next = out_valid_reg & out_stall;
        out_px_next    = out_px_reg;
        out_py_next    = out_py_reg;
        out_sx_next    = out_sx_reg;
        out_sy_next    = out_sy_reg;
        out_num_next   = out_num_reg;
        out_ovf_next   = out_ovf_reg;

        // configuration writes; the host must issue them only while idle, the block does not enforce it
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_TILE_WIDTH:  tile_w_next = pwdata[TILE_W_W-1:0];
                REG_TILE_HEIGHT: tile_h_next = pwdata[TILE_W_W-1:0];
                REG_MAP_WIDTH:   map_w_next  = pwdata[MAP_W_W-1:0];
                REG_TS_COLUMNS:  cols_next   = pwdata[MAP_W_W-1:0];
                default:         ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (text_char == CHAR_NUL)
                    begin
                        // end of layer, pending number dropped
                        accum_next  = '0;
                        digits_next = 1'b0;
                        novf_next   = 1'b0;
                        cnt_next    = '0;
                    end
                    else if (is_digit)
                    begin
                        digits_next = 1'b1;
                        if (acc_sum > ACC_W'(MAX_TILE_ID))
                        begin
                            accum_next = ID_W'(MAX_TILE_ID);
                            novf_next  = 1'b1;
                        end
                        else
                        begin
                            accum_next = acc_sum[ID_W-1:0];
                        end
                    end
                    else if (digits_reg)
                    begin
                        // separator closes the number
                        if (accum_reg != '0)
                        begin
                            id_next    = accum_reg;
                            ovf_next   = novf_reg;
                            dvd_next   = DIV_W'(cnt_reg);
                            dvs_next   = map_w_eff;
                            rem_next   = '0;
                            dcnt_next  = DCNT_W'(DIV_W - 1);
                            pass_next  = 1'b0;
                            state_next = ST_DIV;
                        end
                        if (cnt_reg == CNT_W'(MAP_TILES - 1))
                            cnt_next = '0;
                        else
                            cnt_next = cnt_reg + CNT_W'(1);
                        accum_next  = '0;
                        digits_next = 1'b0;
                        novf_next   = 1'b0;
                    end
                end
            end

            ST_DIV:
            begin
                dvd_next  = dvd_step;
                rem_next  = rem_step;
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == '0)
                begin
                    if (!pass_reg)
                    begin
                        // map position done, start tileset column split
                        q0_next   = dvd_step[CNT_W-1:0];
                        r0_next   = rem_step;
                        dvd_next  = DIV_W'(id_reg - ID_W'(1));
                        dvs_next  = cols_eff;
                        rem_next  = '0;
                        dcnt_next = DCNT_W'(DIV_W - 1);
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        mstep_next = MUL_POS_X;
                        state_next = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                mstep_next = mstep_reg + 2'd1;
                case (mstep_reg)
                    MUL_POS_X: res_px_next = prod[POS_X_W-1:0];
                    MUL_POS_Y: res_py_next = prod[POS_Y_W-1:0];
                    MUL_SRC_X: res_sx_next = prod[POS_X_W-1:0];
                    MUL_SRC_Y:
                    begin
                        res_sy_next = prod[POS_Y_W-1:0];
                        state_next  = ST_OUT;
                    end
                    default: ;
                endcase
            end

            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_px_next    = res_px_reg;
                    out_py_next    = res_py_reg;
                    out_sx_next    = res_sx_reg;
                    out_sy_next    = res_sy_reg;
                    out_num_next   = NUM_W'(id_reg);
                    out_ovf_next   = ovf_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_w_reg    <= TILE_WIDTH_RST;
            tile_h_reg    <= TILE_HEIGHT_RST;
            map_w_reg     <= MAP_WIDTH_RST;
            cols_reg      <= TS_COLUMNS_RST;
            accum_reg     <= '0;
            digits_reg    <= 1'b0;
            novf_reg      <= 1'b0;
            cnt_reg       <= '0;
            state_reg     <= ST_IDLE;
            dcnt_reg      <= '0;
            pass_reg      <= 1'b0;
            mstep_reg     <= MUL_POS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tile_w_reg    <= tile_w_next;
            tile_h_reg    <= tile_h_next;
            map_w_reg     <= map_w_next;
            cols_reg      <= cols_next;
            accum_reg     <= accum_next;
            digits_reg    <= digits_next;
            novf_reg      <= novf_next;
            cnt_reg       <= cnt_next;
            state_reg     <= state_next;
            dcnt_reg      <= dcnt_next;
            pass_reg      <= pass_next;
            mstep_reg     <= mstep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        q0_reg      <= q0_next;
        r0_reg      <= r0_next;
        id_reg      <= id_next;
        ovf_reg     <= ovf_next;
        res_px_reg  <= res_px_next;
        res_py_reg  <= res_py_next;
        res_sx_reg  <= res_sx_next;
        res_sy_reg  <= res_sy_next;
        out_px_reg  <= out_px_next;
        out_py_reg  <= out_py_next;
        out_sx_reg  <= out_sx_next;
        out_sy_reg  <= out_sy_next;
        out_num_reg <= out_num_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = out_px_reg;
    assign pos_y       = out_py_reg;
    assign src_x       = out_sx_reg;
    assign src_y       = out_sy_reg;
    assign tile_number = out_num_reg;
    assign overflowed  = out_ovf_reg;

endmodule

// ----- hw/rtl/tlcd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcd_checker
// port-level checks of the csv tile layer decoder, bound to the top level
// ----------------------------------------------------------------------------
module tlcd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic [tlcd_pkg::CHAR_W-1:0]     text_char,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [tlcd_pkg::POS_X_W-1:0]    pos_x,
    input logic [tlcd_pkg::NUM_W-1:0]      tile_number
);
    import tlcd_pkg::*;

    logic in_txn;
    logic digit_txn;
    logic nul_txn;

    assign in_txn    = in_valid & ~in_stall;
    assign digit_txn = in_txn & (text_char >= CHAR_0) & (text_char <= CHAR_9);
    assign nul_txn   = in_txn & (text_char == CHAR_NUL);

    // a digit never starts the divider
    a_digit_ready: assert property (@(posedge clk) disable iff (!rst_n)
        digit_txn |=> !in_stall)
        else $error("stall after digit transaction");

    // end of layer never starts the divider
    a_nul_ready: assert property (@(posedge clk) disable iff (!rst_n)
        nul_txn |=> !in_stall)
        else $error("stall after end of layer");

    // no tile comes out of a digit
    a_digit_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        digit_txn |=> !(out_valid && !$past(out_valid && out_stall)))
        else $error("result produced by a digit");

    // a new tile only appears at the end of a busy stretch
    a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while not busy");

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(tile_number))
        else $error("stalled output changed");

endmodule

bind tile_layer_csv_decoder tlcd_checker u_tlcd_checker (.*);

// ----- verif/tlcd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlcd_scoreboard
// watches the character, tile and register ports of the csv tile layer
// decoder, predicts every tile it must emit and compares field by field
// ----------------------------------------------------------------------------
module tlcd_scoreboard (
    input  logic                            clk,
    input  logic                            rst_n,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic                            pready,
    input  logic [tlcd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tlcd_pkg::APB_DATA_W-1:0] pwdata,
    // character port
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [tlcd_pkg::CHAR_W-1:0]     text_char,
    // tile port
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [tlcd_pkg::POS_X_W-1:0]    pos_x,
    input  logic [tlcd_pkg::POS_Y_W-1:0]    pos_y,
    input  logic [tlcd_pkg::POS_X_W-1:0]    src_x,
    input  logic [tlcd_pkg::POS_Y_W-1:0]    src_y,
    input  logic [tlcd_pkg::NUM_W-1:0]      tile_number,
    input  logic                            overflowed,
    // status
    output int                              fail_count,
    output int                              pending,
    output int                              tiles_checked,
    output int                              saturated_tiles
);
    import tlcd_pkg::*;

    typedef struct packed {
        logic [POS_X_W-1:0] pos_x;
        logic [POS_Y_W-1:0] pos_y;
        logic [POS_X_W-1:0] src_x;
        logic [POS_Y_W-1:0] src_y;
        logic [NUM_W-1:0]   tile_number;
        logic               overflowed;
    } tile_place_t;

    tile_place_t         expected_tiles[$];

    // shadow of the layout registers
    logic [TILE_W_W-1:0] cfg_tile_w;
    logic [TILE_W_W-1:0] cfg_tile_h;
    logic [MAP_W_W-1:0]  cfg_map_w;
    logic [MAP_W_W-1:0]  cfg_columns;

    // decode state
    longint unsigned     id_accum;
    bit                  in_number;
    bit                  id_saturated;
    longint unsigned     tile_index;

    function automatic void clear_number();
        id_accum     = 0;
        in_number    = 1'b0;
        id_saturated = 1'b0;
    endfunction

    // advance the decode state by one character, queue a tile if one completes
    function automatic void take_char(input logic [CHAR_W-1:0] c);
        tile_place_t     t;
        longint unsigned row_len;
        longint unsigned cols;
        longint unsigned nxt;
        logic [63:0]     prod;
        if (c == CHAR_NUL)
        begin
            clear_number();
            tile_index = 0;
        end
        else if (c >= CHAR_0 && c <= CHAR_9)
        begin
            nxt = id_accum * DEC_BASE + (c - CHAR_0);
            if (nxt > MAX_TILE_ID_DEF)
            begin
                nxt          = MAX_TILE_ID_DEF;
                id_saturated = 1'b1;
            end
            id_accum  = nxt;
            in_number = 1'b1;
        end
        else if (in_number)
        begin
            if (id_accum != 0)
            begin
                // zero width or column count behaves as one
                row_len = (cfg_map_w == 0) ? 1 : cfg_map_w;
                cols    = (cfg_columns == 0) ? 1 : cfg_columns;
                prod = (tile_index % row_len) * cfg_tile_w;
                t.pos_x = prod[POS_X_W-1:0];
                prod = (tile_index / row_len) * cfg_tile_h;
                t.pos_y = prod[POS_Y_W-1:0];
                prod = ((id_accum - 1) % cols) * cfg_tile_w;
                t.src_x = prod[POS_X_W-1:0];
                prod = ((id_accum - 1) / cols) * cfg_tile_h;
                t.src_y = prod[POS_Y_W-1:0];
                prod = id_accum;
                t.tile_number = prod[NUM_W-1:0];
                t.overflowed  = id_saturated;
                expected_tiles.push_back(t);
            end
            tile_index = (tile_index + 1) % MAP_TILES_DEF;
            clear_number();
        end
    endfunction

    task automatic check_field(input string label, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t tile %0d %s: expected %0d, actual %0d",
                     $time, tiles_checked, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tile_place_t want;
        if (!rst_n)
        begin
            cfg_tile_w  = TILE_WIDTH_RST;
            cfg_tile_h  = TILE_HEIGHT_RST;
            cfg_map_w   = MAP_WIDTH_RST;
            cfg_columns = TS_COLUMNS_RST;
            clear_number();
            tile_index = 0;
            expected_tiles.delete();
            pending = 0;
        end
        else
        begin
            // results leave before this edge's character is predicted
            if (out_valid && !out_stall)
            begin
                if (expected_tiles.size() == 0)
                begin
                    fail_count++;
                    $display("%0t unexpected tile: expected none, actual number %0d",
                             $time, tile_number);
                end
                else
                begin
                    want = expected_tiles.pop_front();
                    check_field("pos_x", want.pos_x, pos_x);
                    check_field("pos_y", want.pos_y, pos_y);
                    check_field("src_x", want.src_x, src_x);
                    check_field("src_y", want.src_y, src_y);
                    check_field("tile_number", want.tile_number, tile_number);
                    check_field("overflowed", want.overflowed, overflowed);
                    tiles_checked++;
                    if (want.overflowed)
                        saturated_tiles++;
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_TILE_WIDTH:  cfg_tile_w  = pwdata[TILE_W_W-1:0];
                    REG_TILE_HEIGHT: cfg_tile_h  = pwdata[TILE_W_W-1:0];
                    REG_MAP_WIDTH:   cfg_map_w   = pwdata[MAP_W_W-1:0];
                    REG_TS_COLUMNS:  cfg_columns = pwdata[MAP_W_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                take_char(text_char);
            pending = expected_tiles.size();
        end
    end

endmodule

// ----- verif/tile_layer_csv_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_layer_csv_decoder_test
// feeds the csv tile layer decoder directed and random layer text under
// several tile layouts, with random gaps, output back-pressure and a long
// receiver hold-off; a side checker predicts and compares every tile
// ----------------------------------------------------------------------------
module tile_layer_csv_decoder_test;
    import tlcd_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [APB_ADDR_W-1:0] paddr     = '0;
    logic [APB_DATA_W-1:0] pwdata    = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [CHAR_W-1:0]     text_char = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [POS_X_W-1:0]    pos_x;
    logic [POS_Y_W-1:0]    pos_y;
    logic [POS_X_W-1:0]    src_x;
    logic [POS_Y_W-1:0]    src_y;
    logic [NUM_W-1:0]      tile_number;
    logic                  overflowed;

    int fail_count;
    int pending;
    int tiles_checked;
    int saturated_tiles;

    int chars_sent    = 0;
    int layouts_used  = 0;
    int cycle_count   = 0;
    // steady turns off idling on both sides; hold_req asks for one long hold-off
    bit steady        = 1'b0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    int hold_left     = 0;

    always #HALF_PERIOD clk = ~clk;

    tile_layer_csv_decoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_char   (text_char),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .src_x       (src_x),
        .src_y       (src_y),
        .tile_number (tile_number),
        .overflowed  (overflowed)
    );

    tlcd_scoreboard u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .text_char       (text_char),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .src_x           (src_x),
        .src_y           (src_y),
        .tile_number     (tile_number),
        .overflowed      (overflowed),
        .fail_count      (fail_count),
        .pending         (pending),
        .tiles_checked   (tiles_checked),
        .saturated_tiles (saturated_tiles)
    );

    // receiver side: random stalls, one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= !steady && ($urandom_range(99) < 9);
        end
    end

    // run limit
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d tiles still expected", cycle_count, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one character transaction, with a random gap ahead of it
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < 9)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_char <= c;
        do @(posedge clk); while (in_stall);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // decimal digits of a tile id, optionally with a leading zero
    task automatic send_number(input longint unsigned id, input bit lead_zero);
        logic [CHAR_W-1:0] digs[$];
        longint unsigned   v;
        v = id;
        do
        begin
            digs.push_front(8'(CHAR_0 + v % DEC_BASE));
            v = v / DEC_BASE;
        end
        while (v != 0);
        if (lead_zero)
            send_char(CHAR_0);
        foreach (digs[i])
            send_char(digs[i]);
    endtask

    // mostly well-formed tile lists, some noise bytes and layer ends
    task automatic random_layer(input int count);
        int                target;
        int                pick;
        longint unsigned   id;
        logic [CHAR_W-1:0] sep;
        target = chars_sent + count;
        while (chars_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                send_char(CHAR_NUL);
            end
            else if (pick < 7)
            begin
                send_char(8'($urandom_range(255)));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    id = 0;
                else if (pick < 20)
                    id = $urandom_range(65535);
                else if (pick < 25)
                    id = $urandom_range(999999999, 65536);
                else
                    id = $urandom_range(300, 1);
                send_number(id, $urandom_range(9) == 0);
                // usually a comma, otherwise any byte that is neither digit nor nul
                sep = CH_COMMA;
                if ($urandom_range(99) >= 85)
                begin
                    do
                        sep = 8'($urandom_range(255));
                    while (sep == CHAR_NUL || (sep >= CHAR_0 && sep <= CHAR_9));
                end
                send_char(sep);
            end
        end
    endtask

    // close the phase: drop valid, drain every tile, let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // setup cycle, access cycle, then the port released
    task automatic reg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_layout(input int unsigned tw, input int unsigned th,
                              input int unsigned mw, input int unsigned cols);
        reg_write(REG_TILE_WIDTH, tw);
        reg_write(REG_TILE_HEIGHT, th);
        reg_write(REG_MAP_WIDTH, mw);
        reg_write(REG_TS_COLUMNS, cols);
        layouts_used++;
    endtask

    task automatic random_layout();
        set_layout($urandom_range(1024, 1), $urandom_range(1024, 1),
                   $urandom_range(4096, 1), $urandom_range(4096, 1));
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed text under the reset layout: plain tile, the largest id,
        // an id that saturates, a zero id, separators just outside the digit
        // range and above 127, separators without digits, nul dropping a number
        send_text("1,65535:99999/0");
        send_char(8'hFF);
        send_text("7");
        send_char(8'h80);
        send_text(",,5");
        send_char(CHAR_NUL);

        settle();
        random_layout();
        random_layer(110);

        // smallest layout
        settle();
        set_layout(1, 1, 1, 1);
        random_layer(110);

        // largest in-range layout, with the receiver held off so the block fills
        settle();
        set_layout(1024, 1024, 4096, 4096);
        hold_req = 1'b1;
        random_layer(150);

        // zero map width and column count behave as one
        settle();
        set_layout(2047, 2047, 0, 0);
        random_layer(110);

        // register values above their stated range
        settle();
        set_layout(2047, 2047, 8191, 8191);
        random_layer(110);

        // a stretch with no idling on either side
        settle();
        random_layout();
        steady = 1'b1;
        random_layer(110);

        // one tile per map row with the widest tiles, so the y position
        // steps by a full tile height with every tile
        settle();
        set_layout(2047, 2047, 1, 3);
        send_char(CHAR_NUL);
        repeat (10)
        begin
            send_number($urandom_range(50, 1), 1'b0);
            send_char(CH_COMMA);
        end
        steady = 1'b0;

        settle();
        random_layout();
        random_layer(110);

        settle();
        $display("run covered %0d characters under %0d layouts, %0d tiles checked, %0d saturated",
                 chars_sent, layouts_used, tiles_checked, saturated_tiles);
        $display("zero and out-of-range layouts included; receiver held off once for %0d cycles",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
